FILE: hw/rtl/fcif_pkg.sv
// ----------------------------------------------------------------------------
// fcif_pkg
// Shared constants and codes for the free corridor interval finder.
// ----------------------------------------------------------------------------
`default_nettype none

package fcif_pkg;

    localparam int MAX_OBSTACLES_DEF = 32;
    localparam int FRAC_BITS         = 4;

    // Margin added around non-solid obstacles and the floor of the gap width
    localparam logic [20:0] MARGIN  = 21'(4 << FRAC_BITS);
    localparam logic [19:0] MIN_GAP = 20'(8 << FRAC_BITS);

    // ceil(2^32 / 100): exact floor division by 100 for values below 2^26
    localparam logic [25:0] RECIP_100 = 26'd42949673;

    localparam logic signed [31:0] BAND_LOW_RST  = -32'sd16384;
    localparam logic signed [31:0] BAND_HIGH_RST = 32'sd16384;
    localparam logic [19:0]        HALF_RST      = 20'd64;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [2:0] CLS_SOLID   = 3'd0;
    localparam logic [2:0] CLS_HAZARD  = 3'd1;
    localparam logic [2:0] CLS_UNKNOWN = 3'd2;

    localparam logic [1:0] REG_BAND_LOW  = 2'd0;
    localparam logic [1:0] REG_BAND_HIGH = 2'd1;
    localparam logic [1:0] REG_HALF      = 2'd2;

endpackage

`default_nettype wire

FILE: hw/rtl/fcif_ram.sv
// ----------------------------------------------------------------------------
// fcif_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fcif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/free_corridor_interval_finder.sv
// ----------------------------------------------------------------------------
// free_corridor_interval_finder
// Obstacle store plus a sequencer that builds, sorts and complements the
// blocked vertical intervals over a query window and streams the free gaps.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  s_axis   | in  | tuser kind; tdata class, rect x/y/w/h, dynamic, verified, x ends
//  m_axis   | out | tdata gap low/high; tuser found, uncertain, overflow; tlast
//  cfg      | in  | write enable, register index, write data
//
//  Clear and add are handled when accepted. A query scans every stored
//  obstacle, insertion-sorts each kept interval into the sorted interval
//  RAM and walks that RAM to emit the gaps, paced by its single read port.
//  s_axis_tready is low for the whole query. A stalled m_axis holds the
//  sequencer at its next gap. Reset empties the store; RAM contents persist.
// ----------------------------------------------------------------------------
`default_nettype none

module free_corridor_interval_finder
    import fcif_pkg::*;
#(
    parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // class[2:0] x[34:3] y[66:35] w[98:67] h[130:99] dynamic[131] verified[132]
    // x_near[164:133] x_far[196:165] zero[199:197]
    input  wire logic [199:0] s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // free_low[31:0] free_high[63:32]
    output logic [63:0]       m_axis_tdata,
    // found[0] uncertain[1] overflow[2]
    output logic [2:0]        m_axis_tuser,
    output logic              m_axis_tlast,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_addr,
    input  wire logic [31:0]  i_cfg_wdata
);

    localparam int IW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CW = $clog2(MAX_OBSTACLES + 1);
    localparam int SW = 137;

    typedef enum logic [3:0] {
        S_IDLE, S_MW_MUL, S_MW_MAX, S_SC_RD, S_SC_EV, S_SC_CLIP,
        S_IN_RD, S_IN_CMP, S_IN_WR, S_EM_RD, S_EM_CHK, S_EM_TAIL, S_EM_FIN
    } t_state;

    t_state r_state;

    logic signed [31:0] r_band_low, r_band_high;
    logic [19:0]        r_half;
    logic [CW-1:0]      r_count, r_i, r_n, r_j;
    logic               r_ovf_seen, r_unc;
    logic signed [31:0] r_wlo, r_whi;
    logic [51:0]        r_prod;
    logic [19:0]        r_minw;
    logic signed [34:0] r_lo_raw, r_hi_raw;
    logic               r_keep, r_unc_c;
    logic signed [31:0] r_nlo, r_nhi, r_cursor, r_plo, r_phi;
    logic               r_pv;
    logic               r_o_valid, r_o_found, r_o_last, r_o_unc, r_o_ovf;
    logic signed [31:0] r_o_low, r_o_high;

    // input unpack
    logic [1:0]         w_kind;
    logic [2:0]         w_cls;
    logic signed [31:0] w_rx, w_ry, w_rw, w_rh, w_xn, w_xf;
    logic               w_dyn, w_ver;

    assign w_kind = s_axis_tuser;
    assign w_cls  = s_axis_tdata[2:0];
    assign w_rx   = s_axis_tdata[34:3];
    assign w_ry   = s_axis_tdata[66:35];
    assign w_rw   = s_axis_tdata[98:67];
    assign w_rh   = s_axis_tdata[130:99];
    assign w_dyn  = s_axis_tdata[131];
    assign w_ver  = s_axis_tdata[132];
    assign w_xn   = s_axis_tdata[164:133];
    assign w_xf   = s_axis_tdata[196:165];

    logic w_acc;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // add: edge normalization
    logic signed [32:0] w_x1, w_x2, w_y1, w_y2, w_xlo, w_xhi, w_ylo, w_yhi;
    assign w_x1  = {w_rx[31], w_rx};
    assign w_y1  = {w_ry[31], w_ry};
    assign w_x2  = w_x1 + {w_rw[31], w_rw};
    assign w_y2  = w_y1 + {w_rh[31], w_rh};
    assign w_xlo = (w_x2 < w_x1) ? w_x2 : w_x1;
    assign w_xhi = (w_x2 < w_x1) ? w_x1 : w_x2;
    assign w_ylo = (w_y2 < w_y1) ? w_y2 : w_y1;
    assign w_yhi = (w_y2 < w_y1) ? w_y1 : w_y2;

    logic          w_st_we;
    logic [SW-1:0] w_st_wdata, w_st_rdata;
    assign w_st_we    = w_acc && (w_kind == KIND_ADD) && (r_count < CW'(MAX_OBSTACLES));
    assign w_st_wdata = {w_ver, w_dyn, w_cls, w_yhi, w_ylo, w_xhi, w_xlo};

    fcif_ram #(.WIDTH(SW), .DEPTH(MAX_OBSTACLES), .AW(IW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (w_st_wdata),
        .i_raddr (r_i[IW-1:0]),
        .o_rdata (w_st_rdata)
    );

    // scan evaluation
    logic signed [32:0] w_sxlo, w_sxhi, w_sylo, w_syhi;
    logic [4:0]         w_sflags;
    logic [20:0]        w_grow;
    assign w_sxlo   = w_st_rdata[32:0];
    assign w_sxhi   = w_st_rdata[65:33];
    assign w_sylo   = w_st_rdata[98:66];
    assign w_syhi   = w_st_rdata[131:99];
    assign w_sflags = w_st_rdata[136:132];
    assign w_grow   = (w_sflags[2:0] == CLS_SOLID) ? {1'b0, r_half}
                                                   : {1'b0, r_half} + MARGIN;

    logic signed [34:0] w_blo35, w_bhi35, w_clo, w_chi;
    assign w_blo35 = {{3{r_band_low[31]}}, r_band_low};
    assign w_bhi35 = {{3{r_band_high[31]}}, r_band_high};
    assign w_clo   = (r_lo_raw > w_blo35) ? r_lo_raw : w_blo35;
    assign w_chi   = (r_hi_raw < w_bhi35) ? r_hi_raw : w_bhi35;

    logic [25:0] w_x35;
    assign w_x35 = {1'b0, r_half, 5'b0} + {5'b0, r_half, 1'b0} + {6'b0, r_half};

    // sorted interval RAM
    logic               w_so_we, w_gt;
    logic [IW-1:0]      w_so_raddr;
    logic [63:0]        w_so_wdata, w_so_rdata;
    logic signed [31:0] w_dlo, w_dhi;
    assign w_dlo      = w_so_rdata[31:0];
    assign w_dhi      = w_so_rdata[63:32];
    assign w_gt       = (w_dlo > r_nlo) || ((w_dlo == r_nlo) && (w_dhi > r_nhi));
    assign w_so_we    = ((r_state == S_IN_CMP) && w_gt) || (r_state == S_IN_WR);
    assign w_so_wdata = (r_state == S_IN_WR) ? {r_nhi, r_nlo} : w_so_rdata;
    assign w_so_raddr = (r_state == S_IN_RD) ? IW'(r_j - 1'b1) : r_i[IW-1:0];

    fcif_ram #(.WIDTH(64), .DEPTH(MAX_OBSTACLES), .AW(IW)) u_sorted (
        .i_clk   (i_clk),
        .i_we    (w_so_we),
        .i_waddr (r_j[IW-1:0]),
        .i_wdata (w_so_wdata),
        .i_raddr (w_so_raddr),
        .o_rdata (w_so_rdata)
    );

    // gap tests
    logic signed [32:0] w_minw33, w_gdiff, w_tdiff;
    logic               w_gap, w_tail, w_can_load, w_last_i, w_o_load;
    assign w_minw33   = {13'b0, r_minw};
    assign w_gdiff    = {w_dlo[31], w_dlo} - {r_cursor[31], r_cursor};
    assign w_tdiff    = {r_band_high[31], r_band_high} - {r_cursor[31], r_cursor};
    assign w_gap      = (w_dlo > r_cursor) && (w_gdiff >= w_minw33);
    assign w_tail     = (r_band_high > r_cursor) && (w_tdiff >= w_minw33);
    assign w_can_load = !r_o_valid || m_axis_tready;
    assign w_last_i   = (CW'(r_i + 1'b1) >= r_count);
    assign w_o_load   = w_can_load && (((r_state == S_EM_CHK) && w_gap && r_pv)
                                    || ((r_state == S_EM_TAIL) && w_tail && r_pv)
                                    || (r_state == S_EM_FIN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_band_low  <= BAND_LOW_RST;
            r_band_high <= BAND_HIGH_RST;
            r_half      <= HALF_RST;
            r_count     <= '0;
            r_ovf_seen  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_BAND_LOW:  r_band_low  <= i_cfg_wdata;
                    REG_BAND_HIGH: r_band_high <= i_cfg_wdata;
                    REG_HALF:      r_half      <= i_cfg_wdata[19:0];
                    default: ;
                endcase
            end
            if (r_o_valid && m_axis_tready && !w_o_load) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (w_kind)
                            KIND_CLEAR: begin
                                r_count    <= '0;
                                r_ovf_seen <= 1'b0;
                            end
                            KIND_ADD: begin
                                if (w_st_we) r_count <= CW'(r_count + 1'b1);
                                else         r_ovf_seen <= 1'b1;
                            end
                            KIND_QUERY: begin
                                r_wlo   <= (w_xf < w_xn) ? w_xf : w_xn;
                                r_whi   <= (w_xf < w_xn) ? w_xn : w_xf;
                                r_state <= S_MW_MUL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MW_MUL: begin
                    r_prod  <= w_x35 * RECIP_100;
                    r_state <= S_MW_MAX;
                end
                S_MW_MAX: begin
                    r_minw <= (r_prod[51:32] > MIN_GAP) ? r_prod[51:32] : MIN_GAP;
                    r_i    <= '0;
                    r_n    <= '0;
                    r_unc  <= 1'b0;
                    if (r_count != '0) begin
                        r_state <= S_SC_RD;
                    end else begin
                        r_cursor <= r_band_low;
                        r_pv     <= 1'b0;
                        r_state  <= S_EM_RD;
                    end
                end
                S_SC_RD: r_state <= S_SC_EV;
                S_SC_EV: begin
                    r_keep   <= (w_sflags[2:0] <= CLS_UNKNOWN)
                                && (w_sxhi >= $signed({r_wlo[31], r_wlo}))
                                && (w_sxlo <= $signed({r_whi[31], r_whi}));
                    r_unc_c  <= (w_sflags[2:0] == CLS_UNKNOWN) || w_sflags[3] || !w_sflags[4];
                    r_lo_raw <= {{2{w_sylo[32]}}, w_sylo} - $signed({14'b0, w_grow});
                    r_hi_raw <= {{2{w_syhi[32]}}, w_syhi} + $signed({14'b0, w_grow});
                    r_state  <= S_SC_CLIP;
                end
                S_SC_CLIP: begin
                    if (r_keep && (w_chi > w_clo)) begin
                        r_nlo   <= w_clo[31:0];
                        r_nhi   <= w_chi[31:0];
                        r_unc   <= r_unc | r_unc_c;
                        r_j     <= r_n;
                        r_state <= (r_n != '0) ? S_IN_RD : S_IN_WR;
                    end else begin
                        if (w_last_i) begin
                            r_i      <= '0;
                            r_cursor <= r_band_low;
                            r_pv     <= 1'b0;
                            r_state  <= S_EM_RD;
                        end else begin
                            r_i     <= CW'(r_i + 1'b1);
                            r_state <= S_SC_RD;
                        end
                    end
                end
                S_IN_RD: r_state <= S_IN_CMP;
                S_IN_CMP: begin
                    if (w_gt) begin
                        r_j     <= CW'(r_j - 1'b1);
                        r_state <= (r_j > CW'(1)) ? S_IN_RD : S_IN_WR;
                    end else begin
                        r_state <= S_IN_WR;
                    end
                end
                S_IN_WR: begin
                    r_n <= CW'(r_n + 1'b1);
                    if (w_last_i) begin
                        r_i      <= '0;
                        r_cursor <= r_band_low;
                        r_pv     <= 1'b0;
                        r_state  <= S_EM_RD;
                    end else begin
                        r_i     <= CW'(r_i + 1'b1);
                        r_state <= S_SC_RD;
                    end
                end
                S_EM_RD: r_state <= (r_i < r_n) ? S_EM_CHK : S_EM_TAIL;
                S_EM_CHK: begin
                    if (!(w_gap && r_pv && !w_can_load)) begin
                        if (w_gap) begin
                            if (r_pv) begin
                                r_o_valid <= 1'b1;
                                r_o_low   <= r_plo;
                                r_o_high  <= r_phi;
                                r_o_found <= 1'b1;
                                r_o_last  <= 1'b0;
                                r_o_unc   <= r_unc;
                                r_o_ovf   <= r_ovf_seen;
                            end
                            r_pv  <= 1'b1;
                            r_plo <= r_cursor;
                            r_phi <= w_dlo;
                        end
                        if (w_dhi > r_cursor) r_cursor <= w_dhi;
                        r_i     <= CW'(r_i + 1'b1);
                        r_state <= S_EM_RD;
                    end
                end
                S_EM_TAIL: begin
                    if (!(w_tail && r_pv && !w_can_load)) begin
                        if (w_tail) begin
                            if (r_pv) begin
                                r_o_valid <= 1'b1;
                                r_o_low   <= r_plo;
                                r_o_high  <= r_phi;
                                r_o_found <= 1'b1;
                                r_o_last  <= 1'b0;
                                r_o_unc   <= r_unc;
                                r_o_ovf   <= r_ovf_seen;
                            end
                            r_pv  <= 1'b1;
                            r_plo <= r_cursor;
                            r_phi <= r_band_high;
                        end
                        r_state <= S_EM_FIN;
                    end
                end
                S_EM_FIN: begin
                    if (w_can_load) begin
                        r_o_valid <= 1'b1;
                        r_o_low   <= r_pv ? r_plo : '0;
                        r_o_high  <= r_pv ? r_phi : '0;
                        r_o_found <= r_pv;
                        r_o_last  <= 1'b1;
                        r_o_unc   <= r_unc;
                        r_o_ovf   <= r_ovf_seen;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_high, r_o_low};
    assign m_axis_tuser  = {r_o_ovf, r_o_unc, r_o_found};
    assign m_axis_tlast  = r_o_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_OBSTACLES))
        else $error("obstacle count beyond capacity");

    a_sorted_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_IDLE) && (r_state != S_MW_MUL) && (r_state != S_MW_MAX))
        |-> (r_n <= r_count))
        else $error("more sorted intervals than obstacles");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_kind == KIND_QUERY)) |=> !s_axis_tready)
        else $error("input taken during query");

    a_nogap_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("empty result beat not last");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the free corridor interval finder. Clear, add and
// query beats are sent with random gaps, results are drained with random
// stalls, and every result beat is checked against an in-bench gap predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import fcif_pkg::*;

    localparam int NOBS       = 32;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         cls;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rw;
        logic signed [31:0] rh;
        logic               dyn;
        logic               ver;
        logic signed [31:0] xa;
        logic signed [31:0] xb;
    } t_cmd;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [2:0]  flags;
        logic        last;
    } t_gap;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_wdata = '0;

    free_corridor_interval_finder u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    longint    obs_xlo[NOBS], obs_xhi[NOBS], obs_ylo[NOBS], obs_yhi[NOBS];
    logic [4:0] obs_flags[NOBS];
    int        obs_count = 0;
    bit        store_overflow = 0;
    longint    band_lo = -16384, band_hi = 16384, half_h = 64;

    t_cmd   pending_cmds[$];
    t_gap   expected_gaps[$];
    int     errors = 0;
    int     idle_cycles = 0;
    int     send_wait = 0, recv_wait = 0;

    function automatic longint lmin(longint a, longint b);
        return a < b ? a : b;
    endfunction
    function automatic longint lmax(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function automatic t_gap mk_gap(longint lo, longint hi, bit fnd, bit unc, bit ovf, bit lst);
        t_gap g;
        g.lo = lo[31:0];
        g.hi = hi[31:0];
        g.flags = {ovf, unc, fnd};
        g.last = lst;
        return g;
    endfunction

    task automatic predict_gaps(t_cmd c);
        longint wlo, whi, minw, lo, hi, mg, cur, t;
        longint slo[$], shi[$], mlo[$], mhi[$];
        bit unc;
        int k;
        t_gap outq[$];
        if (c.kind == KIND_CLEAR) begin
            obs_count = 0;
            store_overflow = 0;
        end else if (c.kind == KIND_ADD) begin
            if (obs_count >= NOBS) begin
                store_overflow = 1;
            end else begin
                lo = longint'(c.rx) + longint'(c.rw);
                hi = longint'(c.ry) + longint'(c.rh);
                obs_xlo[obs_count] = lmin(c.rx, lo);
                obs_xhi[obs_count] = lmax(c.rx, lo);
                obs_ylo[obs_count] = lmin(c.ry, hi);
                obs_yhi[obs_count] = lmax(c.ry, hi);
                obs_flags[obs_count] = {c.ver, c.dyn, c.cls};
                obs_count++;
            end
        end else if (c.kind == KIND_QUERY) begin
            wlo = lmin(c.xa, c.xb);
            whi = lmax(c.xa, c.xb);
            minw = lmax(8 * 16, half_h * 35 / 100);
            unc = 0;
            for (int i = 0; i < obs_count; i++) begin
                if (obs_flags[i][2:0] > CLS_UNKNOWN) continue;
                if (!(obs_xhi[i] >= wlo && obs_xlo[i] <= whi)) continue;
                mg = (obs_flags[i][2:0] == CLS_SOLID) ? 0 : 64;
                lo = lmax(obs_ylo[i] - half_h - mg, band_lo);
                hi = lmin(obs_yhi[i] + half_h + mg, band_hi);
                if (hi <= lo) continue;
                k = 0;
                while (k < slo.size() && (slo[k] < lo || (slo[k] == lo && shi[k] <= hi)))
                    k++;
                slo.insert(k, lo);
                shi.insert(k, hi);
                if (obs_flags[i][2:0] == CLS_UNKNOWN || obs_flags[i][3] || !obs_flags[i][4])
                    unc = 1;
            end
            foreach (slo[i]) begin
                if (mlo.size() == 0 || slo[i] > mhi[$]) begin
                    mlo.insert(mlo.size(), slo[i]);
                    mhi.insert(mhi.size(), shi[i]);
                end else begin
                    t = lmax(mhi[$], shi[i]);
                    mhi[mhi.size() - 1] = t;
                end
            end
            cur = band_lo;
            foreach (mlo[i]) begin
                if (mlo[i] > cur && mlo[i] - cur >= minw)
                    outq.insert(outq.size(), mk_gap(cur, mlo[i], 1, unc, store_overflow, 0));
                cur = lmax(cur, mhi[i]);
            end
            if (cur < band_hi && band_hi - cur >= minw)
                outq.insert(outq.size(), mk_gap(cur, band_hi, 1, unc, store_overflow, 0));
            if (outq.size() == 0)
                outq.insert(outq.size(), mk_gap(0, 0, 0, unc, store_overflow, 1));
            outq[outq.size() - 1].last = 1;
            foreach (outq[i]) expected_gaps.insert(expected_gaps.size(), outq[i]);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
        end else begin
            if (s_axis_tvalid) begin
                predict_gaps(pending_cmds.pop_front());
                send_wait = $urandom_range(0, 3);
            end
            if (pending_cmds.size() > 0 && send_wait == 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_cmds[0].kind;
                s_axis_tdata  <= {3'b0, pending_cmds[0].xb, pending_cmds[0].xa,
                                  pending_cmds[0].ver, pending_cmds[0].dyn,
                                  pending_cmds[0].rh, pending_cmds[0].rw,
                                  pending_cmds[0].ry, pending_cmds[0].rx,
                                  pending_cmds[0].cls};
            end else begin
                s_axis_tvalid <= 1'b0;
                if (send_wait > 0) send_wait--;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_gap g;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_gaps.size() == 0) begin
                    $display("%0t unexpected beat: actual %h %h %b %b", $time,
                             m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser,
                             m_axis_tlast);
                    errors++;
                end else begin
                    g = expected_gaps.pop_front();
                    if (m_axis_tdata != {g.hi, g.lo} || m_axis_tuser != g.flags ||
                        m_axis_tlast != g.last) begin
                        $display("%0t mismatch: expected %h %h %b %b actual %h %h %b %b",
                                 $time, g.lo, g.hi, g.flags, g.last, m_axis_tdata[31:0],
                                 m_axis_tdata[63:32], m_axis_tuser, m_axis_tlast);
                        errors++;
                    end
                end
                recv_wait = $urandom_range(0, 3);
            end
            if (recv_wait > 0) begin
                m_axis_tready <= 1'b0;
                recv_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 4);
            1: return 32'h7fff_ffff - $urandom_range(0, 4);
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    function automatic t_cmd rnd_obstacle();
        t_cmd c;
        c.kind = KIND_ADD;
        c.cls = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(3, 7))
                                             : 3'($urandom_range(0, 2));
        c.rx = ($urandom_range(0, 7) == 0) ? rnd_coord()
                                           : 32'($signed($urandom_range(0, 4000)) - 2000);
        c.ry = ($urandom_range(0, 7) == 0) ? rnd_coord()
                                           : 32'($signed($urandom_range(0, 30000)) - 15000);
        c.rw = ($urandom_range(0, 7) == 0) ? rnd_coord()
                                           : 32'($signed($urandom_range(0, 2000)) - 1000);
        c.rh = ($urandom_range(0, 7) == 0) ? rnd_coord()
                                           : 32'($signed($urandom_range(0, 3000)) - 1500);
        c.dyn = 1'($urandom_range(0, 1));
        c.ver = ($urandom_range(0, 3) != 0);
        c.xa = $urandom();
        c.xb = $urandom();
        return c;
    endfunction

    function automatic t_cmd rnd_query();
        t_cmd c;
        c = rnd_obstacle();
        c.kind = KIND_QUERY;
        c.xa = ($urandom_range(0, 5) == 0) ? rnd_coord()
                                           : 32'($signed($urandom_range(0, 5000)) - 2500);
        c.xb = ($urandom_range(0, 5) == 0) ? rnd_coord()
                                           : 32'($signed($urandom_range(0, 5000)) - 2500);
        return c;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_BAND_LOW) band_lo = longint'($signed(val));
        else if (idx == REG_BAND_HIGH) band_hi = longint'($signed(val));
        else half_h = longint'(val[19:0]);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_gaps.size() > 0)
            @(posedge i_clk);
        repeat (1500) @(posedge i_clk);
    endtask

    task automatic queue_cmd(t_cmd c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    initial begin
        t_cmd c;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every kind and class, overflow, ignored kind
        c = rnd_query();
        queue_cmd(c);
        c = rnd_obstacle();
        c.cls = CLS_SOLID; c.rx = 32'h8000_0000; c.rw = 32'h7fff_ffff;
        c.ry = 32'h8000_0000; c.rh = 32'hffff_ffff; c.dyn = 0; c.ver = 1;
        queue_cmd(c);
        c.cls = CLS_HAZARD; c.rx = 32'h7fff_ffff; c.rw = 32'h8000_0000;
        c.ry = 32'h7fff_ffff; c.rh = 32'h8000_0000; c.dyn = 1; c.ver = 0;
        queue_cmd(c);
        for (int i = 0; i < 8; i++) begin
            c = rnd_obstacle();
            c.cls = 3'(i);
            queue_cmd(c);
        end
        c = rnd_query(); c.xa = 32'h8000_0000; c.xb = 32'h7fff_ffff;
        queue_cmd(c);
        c.kind = KIND_UNUSED;
        queue_cmd(c);
        c.kind = KIND_CLEAR;
        queue_cmd(c);
        for (int i = 0; i < 34; i++) queue_cmd(rnd_obstacle());
        c = rnd_query(); c.xa = 32'h8000_0000; c.xb = 32'h7fff_ffff;
        queue_cmd(c);
        c.kind = KIND_CLEAR;
        queue_cmd(c);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: begin
                    write_reg(REG_BAND_LOW, 32'h8000_0000);
                    write_reg(REG_BAND_HIGH, 32'h7fff_ffff);
                    write_reg(REG_HALF, 32'h000f_ffff);
                end
                2: begin
                    write_reg(REG_BAND_LOW, 32'd100);
                    write_reg(REG_BAND_HIGH, 32'd100);
                    write_reg(REG_HALF, 32'd0);
                end
                3: begin
                    write_reg(REG_BAND_LOW, -32'sd4000);
                    write_reg(REG_BAND_HIGH, 32'd6000);
                    write_reg(REG_HALF, 32'd1000);
                end
                4: begin
                    write_reg(REG_BAND_LOW, 32'd5000);
                    write_reg(REG_BAND_HIGH, -32'sd5000);
                end
                5: begin
                    write_reg(REG_BAND_LOW, -32'sd20000);
                    write_reg(REG_BAND_HIGH, 32'd20000);
                    write_reg(REG_HALF, $urandom_range(0, 600));
                end
                default: ;
            endcase
            for (int s = 0; s < 7; s++) begin
                c.kind = KIND_CLEAR;
                if ($urandom_range(0, 3) != 0) queue_cmd(c);
                for (int n = $urandom_range(0, (s == 6) ? 36 : 6); n > 0; n--)
                    queue_cmd(rnd_obstacle());
                if ($urandom_range(0, 9) == 0) begin
                    c.kind = KIND_UNUSED;
                    queue_cmd(c);
                end
                queue_cmd(rnd_query());
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/fcif_pkg.sv
hw/rtl/fcif_ram.sv
hw/rtl/free_corridor_interval_finder.sv
sim/tb_top.sv
